@@ hw/rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sorted list engine
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REM_MIN = 3'd1,
        OP_REM_MAX = 3'd2,
        OP_REM_KEY = 3'd3,
        OP_SEARCH  = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_BAD   = 2'd3
    } err_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] item_value;
        logic [4:0]         read_index;
    } item_t;

    typedef struct packed {
        logic               found;
        logic [4:0]         position;
        logic signed [31:0] data_out;
        logic [5:0]         entry_count;
        logic [1:0]         error_code;
    } result_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic shift_all;
        logic shift_ge;
    } cell_cmd_t;

endpackage

@@ hw/rtl/sorted_list_engine.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted-array priority queue built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// latency: a result beat is presented the cycle after its item beat is taken
// throughput: one item per cycle while the result side is not stalled
// every cell compares and shifts in the same cycle
// reset clears the entry count and the result register valid
// stored entries have no reset; only positions below the count are ever read
// ----------------------------------------------------------------------------
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         valid_reg;
    logic                         valid_next;
    result_t                      result_reg;
    result_t                      result_next;
    logic                         accept;
    logic signed [VALUE_BITS-1:0] key;
    logic signed [VALUE_BITS-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]          first_vec;
    logic [IDX_W-1:0]             pos_terms [CAPACITY];
    logic [IDX_W-1:0]             match_pos;
    logic                         match_found;
    logic signed [VALUE_BITS-1:0] read_data;
    logic                         read_ok;
    logic                         is_full;
    logic                         is_empty;
    cell_cmd_t                    cmd;

    assign accept     = item_valid && !item_stall;
    assign item_stall = valid_reg && result_stall;
    assign key        = VALUE_BITS'(item.item_value);
    assign is_full    = (count_reg == CNT_W'(CAPACITY));
    assign is_empty   = (count_reg == '0);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_BITS-1:0] left_w;
        logic signed [VALUE_BITS-1:0] right_w;

        if (i > 0)
        begin : g_l
            assign left_w = entries[i-1];
        end
        else
        begin : g_l0
            assign left_w = entries[i];
        end

        if (i < CAPACITY - 1)
        begin : g_r
            assign right_w = entries[i+1];
        end
        else
        begin : g_rn
            assign right_w = entries[i];
        end

        sle_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .clk   (clk),
            .en    (accept),
            .cmd   (cmd),
            .count (count_reg),
            .key   (key),
            .left  (left_w),
            .right (right_w),
            .entry (entries[i]),
            .first (first_vec[i])
        );

        assign pos_terms[i] = first_vec[i] ? IDX_W'(i) : '0;
    end

    // sorted contents leave at most one first match, so an or-reduce picks it
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
            match_pos = match_pos | pos_terms[i];
    end

    assign match_found = |first_vec;

    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (item.read_index == 5'(i))
                read_data = entries[i];
        end
    end

    assign read_ok = (32'(item.read_index) < 32'(count_reg)) && (32'(item.read_index) < CAPACITY);

    always_comb
    begin
        cmd                     = '0;
        count_next              = count_reg;
        result_next             = '0;
        result_next.error_code  = ERR_OK;
        case (item.opcode)
            OP_INSERT:
            begin
                if (is_full)
                    result_next.error_code = ERR_FULL;
                else
                begin
                    cmd.ins    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REM_MIN:
            begin
                if (is_empty)
                    result_next.error_code = ERR_EMPTY;
                else
                begin
                    cmd.shift_all = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            OP_REM_MAX:
            begin
                if (is_empty)
                    result_next.error_code = ERR_EMPTY;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            OP_REM_KEY:
            begin
                if (is_empty)
                    result_next.error_code = ERR_EMPTY;
                else if (match_found)
                begin
                    cmd.shift_ge         = 1'b1;
                    count_next           = count_reg - CNT_W'(1);
                    result_next.found    = 1'b1;
                    result_next.position = 5'(match_pos);
                end
            end
            OP_SEARCH:
            begin
                if (match_found)
                begin
                    result_next.found    = 1'b1;
                    result_next.position = 5'(match_pos);
                end
            end
            OP_READ:
            begin
                if (read_ok)
                    result_next.data_out = 32'(read_data);
                else
                    result_next.error_code = ERR_BAD;
            end
            default:
            begin
                result_next.error_code = ERR_BAD;
            end
        endcase
        result_next.entry_count = 6'(count_next);
    end

    assign valid_next = accept || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_one_first: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_vec))
        else $error("more than one first match in chain");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("accepted item left no result beat");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == OP_INSERT && is_full) |=> $stable(count_reg))
        else $error("insert on full list changed count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without an item beat");

endmodule

@@ hw/rtl/sle_cell.sv @@
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted chain: holds an entry, compares it with the key and
// takes its next value from itself, a neighbor or the key
// ----------------------------------------------------------------------------
module sle_cell
    import sle_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CNT_W      = 6,
    parameter int INDEX      = 0
)
(
    input  logic                         clk,
    input  logic                         en,
    input  cell_cmd_t                    cmd,
    input  logic [CNT_W-1:0]             count,
    input  logic signed [VALUE_BITS-1:0] key,
    input  logic signed [VALUE_BITS-1:0] left,
    input  logic signed [VALUE_BITS-1:0] right,
    output logic signed [VALUE_BITS-1:0] entry,
    output logic                         first
);

    localparam bit HAS_LEFT = (INDEX > 0);

    logic signed [VALUE_BITS-1:0] entry_reg;
    logic signed [VALUE_BITS-1:0] entry_next;
    logic                         mine_valid;
    logic                         left_valid;
    logic                         self_gt;
    logic                         left_gt;
    logic                         self_ge;

    assign mine_valid = (CNT_W'(INDEX) < count);
    assign left_valid = HAS_LEFT && (CNT_W'(INDEX) <= count);
    assign self_gt    = mine_valid && (entry_reg > key);
    assign self_ge    = mine_valid && (entry_reg >= key);
    assign left_gt    = left_valid && (left > key);
    assign first      = mine_valid && (entry_reg == key) && !(left_valid && (left == key));

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (left_gt)
                entry_next = left;
            else if (self_gt || !mine_valid)
                entry_next = key;
        end
        else if (cmd.shift_all || (cmd.shift_ge && self_ge))
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ sim/sorted_list_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_engine_test
// Self-checking bench for the sorted list engine: a directed table covering
// empty lists, value extremes and unused opcodes, then about 500 random beats
// in fill, drain and mixed phases, each checked against a shadow copy of the
// sorted list, with random idling on both channels
// ----------------------------------------------------------------------------
module sorted_list_engine_test;
    import sle_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int RANDOM_ITEMS  = 500;
    localparam int DIRECTED_ROWS = 25;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_AT_BEAT  = 150;
    localparam int PRINT_LIMIT   = 40;

    localparam logic [2:0] OPC_SPARE_LO = 3'd6;
    localparam logic [2:0] OPC_SPARE_HI = 3'd7;

    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_t;

    typedef struct {
        item_t   beat;
        bit      fixed;
        result_t want;
    } stim_row_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic signed [31:0] shadow_vals [CAPACITY];
    int                 shadow_count = 0;
    result_t            pending_results [$];
    stim_row_t          directed_rows [DIRECTED_ROWS];

    int  fail_count    = 0;
    int  beats_in      = 0;
    int  beats_out     = 0;
    int  full_rejects  = 0;
    int  empty_rejects = 0;
    int  key_hits      = 0;
    int  good_reads    = 0;
    int  input_stalls  = 0;
    bit  tx_quiet      = 1'b0;

    sorted_list_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int find_match(logic signed [31:0] key);
        int i;
        for (i = 0; i < shadow_count; i++)
            if (shadow_vals[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void drop_entry(int at);
        int i;
        for (i = at; i + 1 < shadow_count; i++)
            shadow_vals[i] = shadow_vals[i + 1];
        shadow_count--;
    endfunction

    function automatic result_t update_shadow_list(item_t beat);
        result_t            res;
        logic signed [31:0] v;
        int                 i;
        int                 pos;
        res = '0;
        v   = beat.item_value;
        case (beat.opcode)
            OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    res.error_code = ERR_FULL;
                else
                begin
                    i = shadow_count;
                    while (i > 0 && shadow_vals[i - 1] > v)
                    begin
                        shadow_vals[i] = shadow_vals[i - 1];
                        i--;
                    end
                    shadow_vals[i] = v;
                    shadow_count++;
                end
            end
            OP_REM_MIN:
            begin
                if (shadow_count == 0)
                    res.error_code = ERR_EMPTY;
                else
                    drop_entry(0);
            end
            OP_REM_MAX:
            begin
                if (shadow_count == 0)
                    res.error_code = ERR_EMPTY;
                else
                    shadow_count--;
            end
            OP_REM_KEY:
            begin
                if (shadow_count == 0)
                    res.error_code = ERR_EMPTY;
                else
                begin
                    pos = find_match(v);
                    if (pos >= 0)
                    begin
                        res.found    = 1'b1;
                        res.position = 5'(pos);
                        drop_entry(pos);
                    end
                end
            end
            OP_SEARCH:
            begin
                pos = find_match(v);
                if (pos >= 0)
                begin
                    res.found    = 1'b1;
                    res.position = 5'(pos);
                end
            end
            OP_READ:
            begin
                if (int'(beat.read_index) < shadow_count)
                    res.data_out = shadow_vals[beat.read_index];
                else
                    res.error_code = ERR_BAD;
            end
            default:
                res.error_code = ERR_BAD;
        endcase
        res.entry_count = 6'(shadow_count);
        return res;
    endfunction

    function automatic stim_row_t mk_row(logic [2:0] op, logic signed [31:0] v,
                                         logic [4:0] idx, bit fixed, logic fnd,
                                         logic [4:0] pos, logic signed [31:0] data,
                                         logic [5:0] cnt, logic [1:0] err);
        stim_row_t row;
        row.beat  = '{opcode: op, item_value: v, read_index: idx};
        row.fixed = fixed;
        row.want  = '{found: fnd, position: pos, data_out: data,
                      entry_count: cnt, error_code: err};
        return row;
    endfunction

    function automatic logic [2:0] pick_op(phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:
            begin
                if (r < 75)      return OP_INSERT;
                else if (r < 80) return OP_REM_MIN;
                else if (r < 85) return OP_REM_MAX;
                else if (r < 88) return OP_REM_KEY;
                else if (r < 93) return OP_SEARCH;
                else if (r < 98) return OP_READ;
            end
            PH_DRAIN:
            begin
                if (r < 15)      return OP_INSERT;
                else if (r < 40) return OP_REM_MIN;
                else if (r < 60) return OP_REM_MAX;
                else if (r < 75) return OP_REM_KEY;
                else if (r < 85) return OP_SEARCH;
                else if (r < 96) return OP_READ;
            end
            default:
            begin
                if (r < 35)      return OP_INSERT;
                else if (r < 45) return OP_REM_MIN;
                else if (r < 55) return OP_REM_MAX;
                else if (r < 70) return OP_REM_KEY;
                else if (r < 82) return OP_SEARCH;
                else if (r < 96) return OP_READ;
            end
        endcase
        return (r % 2 == 0) ? OPC_SPARE_LO : OPC_SPARE_HI;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'(int'($urandom_range(0, 15)) - 8);
        if (r < 6 && shadow_count > 0)
            return shadow_vals[$urandom_range(0, shadow_count - 1)];
        if (r == 6)
            return ($urandom_range(0, 1) == 1) ? VAL_MAX : VAL_MIN;
        return $urandom;
    endfunction

    function automatic logic [4:0] pick_index();
        if ($urandom_range(0, 3) != 0 && shadow_count > 0)
            return 5'($urandom_range(0, shadow_count < 31 ? shadow_count : 31));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic flag_mismatch(string label, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
    endtask

    task automatic check_result_beat(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
                $display("%0t: result beat with nothing expected, expected none, got %h",
                         $time, got);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.found !== want.found)
                flag_mismatch("found", want.found, got.found);
            if (got.position !== want.position)
                flag_mismatch("position", want.position, got.position);
            if (got.data_out !== want.data_out)
                flag_mismatch("data_out", want.data_out, got.data_out);
            if (got.entry_count !== want.entry_count)
                flag_mismatch("entry_count", want.entry_count, got.entry_count);
            if (got.error_code !== want.error_code)
                flag_mismatch("error_code", want.error_code, got.error_code);
        end
    endtask

    // entered and left just after a falling edge
    task automatic send_item(item_t beat, bit fixed, result_t want);
        result_t pred;
        int      gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= beat;
        item_valid <= 1'b1;
        do
        begin
            @(posedge clk);
            if (item_stall)
                input_stalls++;
        end
        while (item_stall);
        pred = update_shadow_list(beat);
        pending_results.push_back(fixed ? want : pred);
        beats_in++;
        if (pred.error_code == ERR_FULL)
            full_rejects++;
        if (pred.error_code == ERR_EMPTY)
            empty_rejects++;
        if (pred.found)
            key_hits++;
        if (beat.opcode == OP_READ && pred.error_code == ERR_OK)
            good_reads++;
        @(negedge clk);
    endtask

    // result side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int cycle_no;
        int stall_left;
        int hold_left;
        bit hold_done;
        bit rx_quiet;
        bit stall_now;
        int r;
        cycle_no   = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        rx_quiet   = 1'b0;
        forever
        begin
            @(negedge clk);
            cycle_no++;
            if (cycle_no % 64 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            if (!hold_done && beats_out >= HOLD_AT_BEAT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_now = 1'b1;
            end
            else if (rx_quiet)
                stall_now = 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    stall_now = 1'b0;
                else
                begin
                    stall_now  = 1'b1;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
                end
            end
            result_stall <= stall_now;
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                beats_out++;
                check_result_beat(result);
            end
        end
    end

    initial
    begin
        item_t  beat;
        phase_t phase;
        int     n;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_rows = '{
            mk_row(OP_REM_MIN,   0,       0,  1, 0, 0, 0,       0, ERR_EMPTY),
            mk_row(OP_REM_MAX,   0,       0,  1, 0, 0, 0,       0, ERR_EMPTY),
            mk_row(OP_REM_KEY,   5,       0,  1, 0, 0, 0,       0, ERR_EMPTY),
            mk_row(OP_SEARCH,    0,       0,  1, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_READ,      0,       0,  1, 0, 0, 0,       0, ERR_BAD),
            mk_row(OPC_SPARE_LO, 0,       0,  1, 0, 0, 0,       0, ERR_BAD),
            mk_row(OPC_SPARE_HI, -1,      31, 1, 0, 0, 0,       0, ERR_BAD),
            mk_row(OP_INSERT,    VAL_MAX, 0,  1, 0, 0, 0,       1, ERR_OK),
            mk_row(OP_INSERT,    VAL_MIN, 0,  1, 0, 0, 0,       2, ERR_OK),
            mk_row(OP_READ,      0,       0,  1, 0, 0, VAL_MIN, 2, ERR_OK),
            mk_row(OP_READ,      0,       1,  1, 0, 0, VAL_MAX, 2, ERR_OK),
            mk_row(OP_READ,      0,       2,  1, 0, 0, 0,       2, ERR_BAD),
            mk_row(OP_READ,      0,       31, 1, 0, 0, 0,       2, ERR_BAD),
            mk_row(OP_INSERT,    0,       0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_INSERT,    0,       0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_INSERT,    -1,      0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_SEARCH,    0,       0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_SEARCH,    12345,   0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_SEARCH,    VAL_MAX, 0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_REM_KEY,   0,       0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_REM_KEY,   777,     0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_REM_MIN,   0,       0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_REM_MAX,   0,       0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_READ,      0,       0,  0, 0, 0, 0,       0, ERR_OK),
            mk_row(OP_SEARCH,    -1,      0,  0, 0, 0, 0,       0, ERR_OK)
        };

        foreach (directed_rows[i])
            send_item(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want);

        phase = PH_FILL;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                phase    = phase_t'((n / 50) % 3);
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            beat.opcode     = pick_op(phase);
            beat.item_value = pick_value();
            beat.read_index = pick_index();
            send_item(beat, 1'b0, '0);
        end
        item_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d item beats and %0d result beats, %0d full and %0d empty rejects",
                 beats_in, beats_out, full_rejects, empty_rejects);
        $display("with %0d key hits, %0d reads in range, %0d cycles of input stall",
                 key_hits, good_reads, input_stalls);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sle_pkg.sv
hw/rtl/sle_cell.sv
hw/rtl/sorted_list_engine.sv
sim/sorted_list_engine_test.sv
